// File: hw/rtl/mlsam_pkg.sv
// Shared types and operation codes for the load/store align and merge unit.
package mlsam_pkg;

	typedef logic [4:0]  op_code_t;
	typedef logic [31:0] addr_t;
	typedef logic [4:0]  idx_t;
	typedef logic [63:0] data_t;
	typedef logic [1:0]  size_t;

	localparam op_code_t OP_LW   = 5'd0;
	localparam op_code_t OP_LWU  = 5'd1;
	localparam op_code_t OP_LH   = 5'd2;
	localparam op_code_t OP_LHU  = 5'd3;
	localparam op_code_t OP_LB   = 5'd4;
	localparam op_code_t OP_LBU  = 5'd5;
	localparam op_code_t OP_LD   = 5'd6;
	localparam op_code_t OP_LWC1 = 5'd7;
	localparam op_code_t OP_LDC1 = 5'd8;
	localparam op_code_t OP_LL   = 5'd9;
	localparam op_code_t OP_LWL  = 5'd10;
	localparam op_code_t OP_LWR  = 5'd11;
	localparam op_code_t OP_LDL  = 5'd12;
	localparam op_code_t OP_LDR  = 5'd13;
	localparam op_code_t OP_SW   = 5'd14;
	localparam op_code_t OP_SH   = 5'd15;
	localparam op_code_t OP_SB   = 5'd16;
	localparam op_code_t OP_SD   = 5'd17;
	localparam op_code_t OP_SWC1 = 5'd18;
	localparam op_code_t OP_SDC1 = 5'd19;
	localparam op_code_t OP_SC   = 5'd20;
	localparam op_code_t OP_SWL  = 5'd21;
	localparam op_code_t OP_SWR  = 5'd22;
	localparam op_code_t OP_SDL  = 5'd23;
	localparam op_code_t OP_SDR  = 5'd24;

	localparam size_t SZ_BYTE  = 2'd0;
	localparam size_t SZ_HALF  = 2'd1;
	localparam size_t SZ_WORD  = 2'd2;
	localparam size_t SZ_DWORD = 2'd3;

	localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;
	localparam data_t       MASK64 = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic  reg_write;
		idx_t  write_index;
		data_t reg_result;
		logic  mem_write;
		addr_t mem_addr;
		size_t mem_size;
		data_t mem_wdata;
		logic  code_invalidate;
		logic  bad_op;
	} rsp_t;

endpackage

// File: hw/rtl/mlsam_req_if.sv
// Request channel: one memory access with its register and read data.
interface mlsam_req_if import mlsam_pkg::*;;
	logic     valid;
	logic     ready;
	op_code_t op;
	addr_t    eff_addr;
	idx_t     target_index;
	data_t    reg_value;
	data_t    mem_data;
	logic     mem_ok;

	modport source (output valid, op, eff_addr, target_index, reg_value, mem_data, mem_ok,
		input ready);
	modport sink (input valid, op, eff_addr, target_index, reg_value, mem_data, mem_ok,
		output ready);
endinterface

// File: hw/rtl/mlsam_rsp_if.sv
// Response channel: register write-back and store request of one access.
interface mlsam_rsp_if import mlsam_pkg::*;;
	logic  valid;
	logic  ready;
	logic  reg_write;
	idx_t  write_index;
	data_t reg_result;
	logic  mem_write;
	addr_t mem_addr;
	size_t mem_size;
	data_t mem_wdata;
	logic  code_invalidate;
	logic  bad_op;

	modport source (output valid, reg_write, write_index, reg_result, mem_write, mem_addr,
		mem_size, mem_wdata, code_invalidate, bad_op, input ready);
	modport sink (input valid, reg_write, write_index, reg_result, mem_write, mem_addr,
		mem_size, mem_wdata, code_invalidate, bad_op, output ready);
endinterface

// File: hw/rtl/mips_load_store_align_merge_top.sv
// Request path: an accepted request is held in the input register, then its response in the result register.
// Throughput: one request per cycle while responses are taken; the single-pass align/merge logic sets this figure.
// A stalled response holds the result register; the input register still takes a new request
// whenever the result register drains in the same cycle.
// Reset: arst_n asynchronously clears both stage valids and the LL/SC link bit.
module mips_load_store_align_merge_top import mlsam_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	mlsam_req_if.sink    req,
	mlsam_rsp_if.source  rsp
);

	logic     valid_s1;
	op_code_t op_s1;
	addr_t    addr_s1;
	idx_t     idx_s1;
	data_t    reg_s1;
	data_t    mem_s1;
	logic     ok_s1;

	logic     valid_s2;
	rsp_t     rsp_s2;

	logic     link_q;

	logic     adv_s1;
	logic     take_s2;
	rsp_t     rsp_d;
	logic     link_d;

	assign take_s2   = !valid_s2 || rsp.ready;
	assign adv_s1    = valid_s1 && take_s2;
	assign req.ready = !valid_s1 || take_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.op;
			addr_s1 <= req.eff_addr;
			idx_s1  <= req.target_index;
			reg_s1  <= req.reg_value;
			mem_s1  <= req.mem_data;
			ok_s1   <= req.mem_ok;
		end
	end

	always_comb begin
		logic [31:0] w32;
		logic [31:0] r32;
		logic [31:0] m32;
		logic [31:0] mrg32;
		data_t       m64;
		data_t       rsh;
		data_t       res;
		data_t       wdata;
		addr_t       maddr;
		size_t       sz;
		logic [5:0]  sh4;
		logic [5:0]  shr4;
		logic [5:0]  sh8;
		logic [5:0]  shr8;
		logic        rw;
		logic        mw;
		logic        bad;
		logic        lw_merge;

		w32      = mem_s1[31:0];
		r32      = reg_s1[31:0];
		sh4      = {1'b0, addr_s1[1:0], 3'b000};
		shr4     = {1'b0, ~addr_s1[1:0], 3'b000};
		sh8      = {addr_s1[2:0], 3'b000};
		shr8     = {~addr_s1[2:0], 3'b000};
		rsh      = reg_s1 >> sh4;
		m32      = '0;
		m64      = '0;
		mrg32    = '0;
		res      = '0;
		wdata    = '0;
		maddr    = addr_s1;
		sz       = SZ_BYTE;
		rw       = 1'b0;
		mw       = 1'b0;
		bad      = 1'b0;
		lw_merge = 1'b0;
		link_d   = link_q;

		case (op_s1)
			OP_LW: begin
				res = {{32{w32[31]}}, w32};
				rw  = ok_s1;
			end
			OP_LWU, OP_LWC1: begin
				res = {32'd0, w32};
				rw  = ok_s1;
			end
			OP_LH: begin
				res = {{48{mem_s1[15]}}, mem_s1[15:0]};
				rw  = ok_s1;
			end
			OP_LHU: begin
				res = {48'd0, mem_s1[15:0]};
				rw  = ok_s1;
			end
			OP_LB: begin
				res = {{56{mem_s1[7]}}, mem_s1[7:0]};
				rw  = ok_s1;
			end
			OP_LBU: begin
				res = {56'd0, mem_s1[7:0]};
				rw  = ok_s1;
			end
			OP_LD, OP_LDC1: begin
				res = mem_s1;
				rw  = ok_s1;
			end
			OP_LL: begin
				res = {{32{w32[31]}}, w32};
				rw  = ok_s1;
				if (ok_s1) begin
					link_d = 1'b1;
				end
			end
			OP_LWL: begin
				m32      = MASK32 << sh4;
				mrg32    = (r32 & ~m32) | ((w32 << sh4) & m32);
				lw_merge = 1'b1;
				rw       = ok_s1;
			end
			OP_LWR: begin
				m32      = MASK32 >> shr4;
				mrg32    = (r32 & ~m32) | ((w32 >> shr4) & m32);
				lw_merge = 1'b1;
				rw       = ok_s1;
			end
			OP_LDL: begin
				m64 = MASK64 << sh8;
				res = (reg_s1 & ~m64) | ((mem_s1 << sh8) & m64);
				rw  = ok_s1;
			end
			OP_LDR: begin
				m64 = MASK64 >> shr8;
				res = (reg_s1 & ~m64) | ((mem_s1 >> shr8) & m64);
				rw  = ok_s1;
			end
			OP_SW, OP_SWC1: begin
				mw    = 1'b1;
				sz    = SZ_WORD;
				wdata = reg_s1;
			end
			OP_SH: begin
				mw    = 1'b1;
				sz    = SZ_HALF;
				wdata = reg_s1;
			end
			OP_SB: begin
				mw    = 1'b1;
				sz    = SZ_BYTE;
				wdata = reg_s1;
			end
			OP_SD, OP_SDC1: begin
				mw    = 1'b1;
				sz    = SZ_DWORD;
				wdata = reg_s1;
			end
			OP_SC: begin
				mw     = link_q;
				sz     = SZ_WORD;
				wdata  = reg_s1;
				rw     = 1'b1;
				res    = {63'd0, link_q};
				link_d = 1'b0;
			end
			OP_SWL: begin
				m32   = MASK32 >> sh4;
				mrg32 = (w32 & ~m32) | (rsh[31:0] & m32);
				wdata = {32'd0, mrg32};
				mw    = 1'b1;
				sz    = SZ_WORD;
				maddr = {addr_s1[31:2], 2'b00};
			end
			OP_SWR: begin
				m32   = MASK32 << shr4;
				mrg32 = (w32 & ~m32) | ((r32 << shr4) & m32);
				wdata = {32'd0, mrg32};
				mw    = 1'b1;
				sz    = SZ_WORD;
				maddr = {addr_s1[31:2], 2'b00};
			end
			OP_SDL: begin
				m64   = MASK64 >> sh8;
				wdata = (mem_s1 & ~m64) | ((reg_s1 >> sh8) & m64);
				mw    = 1'b1;
				sz    = SZ_DWORD;
				maddr = {addr_s1[31:3], 3'b000};
			end
			OP_SDR: begin
				m64   = MASK64 << shr8;
				wdata = (mem_s1 & ~m64) | ((reg_s1 << shr8) & m64);
				mw    = 1'b1;
				sz    = SZ_DWORD;
				maddr = {addr_s1[31:3], 3'b000};
			end
			default: begin
				bad = 1'b1;
			end
		endcase

		if (lw_merge) begin
			res = {{32{mrg32[31]}}, mrg32};
		end

		unique case (sz)
			SZ_BYTE:  wdata = {56'd0, wdata[7:0]};
			SZ_HALF:  wdata = {48'd0, wdata[15:0]};
			SZ_WORD:  wdata = {32'd0, wdata[31:0]};
			SZ_DWORD: wdata = wdata;
			default:  wdata = wdata;
		endcase

		rsp_d.reg_write       = rw;
		rsp_d.write_index     = idx_s1;
		rsp_d.reg_result      = rw ? res : '0;
		rsp_d.mem_write       = mw;
		rsp_d.mem_addr        = mw ? maddr : '0;
		rsp_d.mem_size        = mw ? sz : SZ_BYTE;
		rsp_d.mem_wdata       = mw ? wdata : '0;
		rsp_d.code_invalidate = mw;
		rsp_d.bad_op          = bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			link_q   <= 1'b0;
		end else begin
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				link_q <= link_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.reg_write       = rsp_s2.reg_write;
	assign rsp.write_index     = rsp_s2.write_index;
	assign rsp.reg_result      = rsp_s2.reg_result;
	assign rsp.mem_write       = rsp_s2.mem_write;
	assign rsp.mem_addr        = rsp_s2.mem_addr;
	assign rsp.mem_size        = rsp_s2.mem_size;
	assign rsp.mem_wdata       = rsp_s2.mem_wdata;
	assign rsp.code_invalidate = rsp_s2.code_invalidate;
	assign rsp.bad_op          = rsp_s2.bad_op;

	a_sc_unlinked_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (op_s1 == OP_SC) && !link_q |=> !rsp_s2.mem_write)
		else $error("store-conditional issued a store without a link");

	a_sc_clears_link: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (op_s1 == OP_SC) |=> !link_q)
		else $error("link bit survived a store-conditional");

	a_bad_op_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.bad_op |-> !rsp_s2.reg_write && !rsp_s2.mem_write)
		else $error("unknown operation produced a write");

	a_link_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(link_q))
		else $error("link bit changed without an advancing request");

endmodule

// File: sim/mips_load_store_align_merge_top_tb.sv
`timescale 1ns / 100ps
// Randomized handshake testbench with a scoreboard for the load/store align and merge unit.
module mips_load_store_align_merge_top_tb;
	import mlsam_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;

	class access_scoreboard;
		rsp_t due_responses[$];
		logic link_set = 1'b0;
		int   failures = 0;

		function int pending();
			return due_responses.size();
		endfunction

		function data_t sext_word(data_t v);
			return {{32{v[31]}}, v[31:0]};
		endfunction

		function string fmt_rsp(rsp_t r);
			return $sformatf("wr=%0b idx=%0d res=%h mw=%0b addr=%h sz=%0d wd=%h ci=%0b bad=%0b",
				r.reg_write, r.write_index, r.reg_result, r.mem_write, r.mem_addr, r.mem_size,
				r.mem_wdata, r.code_invalidate, r.bad_op);
		endfunction

		function rsp_t merge_access(op_code_t op, addr_t addr, idx_t idx, data_t r, data_t m,
			logic ok);
			rsp_t        o;
			data_t       lo32, w32, mask, res, wdata;
			int unsigned b4, b8, sh;
			logic        rw, mw, bad;
			size_t       sz;
			addr_t       maddr;
			lo32  = data_t'(MASK32);
			w32   = m & lo32;
			b4    = {30'd0, addr[1:0]};
			b8    = {29'd0, addr[2:0]};
			res   = '0;
			wdata = '0;
			maddr = addr;
			sz    = SZ_BYTE;
			rw    = 1'b0;
			mw    = 1'b0;
			bad   = 1'b0;
			case (op)
				OP_LW: begin
					res = sext_word(m);
					rw  = ok;
				end
				OP_LWU, OP_LWC1: begin
					res = w32;
					rw  = ok;
				end
				OP_LH: begin
					res = {{48{m[15]}}, m[15:0]};
					rw  = ok;
				end
				OP_LHU: begin
					res = {48'b0, m[15:0]};
					rw  = ok;
				end
				OP_LB: begin
					res = {{56{m[7]}}, m[7:0]};
					rw  = ok;
				end
				OP_LBU: begin
					res = {56'b0, m[7:0]};
					rw  = ok;
				end
				OP_LD, OP_LDC1: begin
					res = m;
					rw  = ok;
				end
				OP_LL: begin
					res = sext_word(m);
					rw  = ok;
					if (ok)
						link_set = 1'b1;
				end
				OP_LWL: begin
					sh   = b4 * 8;
					mask = (lo32 << sh) & lo32;
					res  = sext_word((r & ~mask) | ((w32 << sh) & mask));
					rw   = ok;
				end
				OP_LWR: begin
					sh   = (3 - b4) * 8;
					mask = lo32 >> sh;
					res  = sext_word((r & ~mask) | ((w32 >> sh) & mask));
					rw   = ok;
				end
				OP_LDL: begin
					sh   = b8 * 8;
					mask = MASK64 << sh;
					res  = (r & ~mask) | ((m << sh) & mask);
					rw   = ok;
				end
				OP_LDR: begin
					sh   = (7 - b8) * 8;
					mask = MASK64 >> sh;
					res  = (r & ~mask) | ((m >> sh) & mask);
					rw   = ok;
				end
				OP_SW, OP_SWC1: begin
					mw    = 1'b1;
					sz    = SZ_WORD;
					wdata = r;
				end
				OP_SH: begin
					mw    = 1'b1;
					sz    = SZ_HALF;
					wdata = r;
				end
				OP_SB: begin
					mw    = 1'b1;
					sz    = SZ_BYTE;
					wdata = r;
				end
				OP_SD, OP_SDC1: begin
					mw    = 1'b1;
					sz    = SZ_DWORD;
					wdata = r;
				end
				OP_SC: begin
					mw       = link_set;
					sz       = SZ_WORD;
					wdata    = r;
					rw       = 1'b1;
					res      = data_t'(link_set);
					link_set = 1'b0;
				end
				OP_SWL: begin
					sh    = b4 * 8;
					mask  = lo32 >> sh;
					wdata = (w32 & ~mask) | ((r >> sh) & mask);
					mw    = 1'b1;
					sz    = SZ_WORD;
					maddr = {addr[31:2], 2'b00};
				end
				OP_SWR: begin
					sh    = (3 - b4) * 8;
					mask  = (lo32 << sh) & lo32;
					wdata = (w32 & ~mask) | ((r << sh) & mask);
					mw    = 1'b1;
					sz    = SZ_WORD;
					maddr = {addr[31:2], 2'b00};
				end
				OP_SDL: begin
					sh    = b8 * 8;
					mask  = MASK64 >> sh;
					wdata = (m & ~mask) | ((r >> sh) & mask);
					mw    = 1'b1;
					sz    = SZ_DWORD;
					maddr = {addr[31:3], 3'b000};
				end
				OP_SDR: begin
					sh    = (7 - b8) * 8;
					mask  = MASK64 << sh;
					wdata = (m & ~mask) | ((r << sh) & mask);
					mw    = 1'b1;
					sz    = SZ_DWORD;
					maddr = {addr[31:3], 3'b000};
				end
				default: bad = 1'b1;
			endcase
			case (sz)
				SZ_BYTE: mask = 64'hFF;
				SZ_HALF: mask = 64'hFFFF;
				SZ_WORD: mask = lo32;
				default: mask = MASK64;
			endcase
			o.reg_write       = rw;
			o.write_index     = idx;
			o.reg_result      = rw ? res : '0;
			o.mem_write       = mw;
			o.mem_addr        = mw ? maddr : '0;
			o.mem_size        = mw ? sz : SZ_BYTE;
			o.mem_wdata       = mw ? (wdata & mask) : '0;
			o.code_invalidate = mw;
			o.bad_op          = bad;
			return o;
		endfunction

		function void note_request(op_code_t op, addr_t addr, idx_t idx, data_t r, data_t m,
			logic ok);
			due_responses.push_back(merge_access(op, addr, idx, r, m, ok));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (due_responses.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: response with no request outstanding: %s", $realtime,
						fmt_rsp(got));
				return;
			end
			want = due_responses.pop_front();
			if (got.reg_write !== want.reg_write || got.write_index !== want.write_index ||
				got.reg_result !== want.reg_result || got.mem_write !== want.mem_write ||
				got.mem_addr !== want.mem_addr || got.mem_size !== want.mem_size ||
				got.mem_wdata !== want.mem_wdata ||
				got.code_invalidate !== want.code_invalidate || got.bad_op !== want.bad_op) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("%0t: response mismatch", $realtime);
					$display("  expected %s", fmt_rsp(want));
					$display("  actual   %s", fmt_rsp(got));
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   idle_cycles = 0;

	access_scoreboard board;

	mlsam_req_if req_ch ();
	mlsam_rsp_if rsp_ch ();

	mips_load_store_align_merge_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		rsp_t got;
		logic progress;
		progress = 1'b0;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			board.note_request(req_ch.op, req_ch.eff_addr, req_ch.target_index,
				req_ch.reg_value, req_ch.mem_data, req_ch.mem_ok);
			progress = 1'b1;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = {rsp_ch.reg_write, rsp_ch.write_index, rsp_ch.reg_result, rsp_ch.mem_write,
				rsp_ch.mem_addr, rsp_ch.mem_size, rsp_ch.mem_wdata, rsp_ch.code_invalidate,
				rsp_ch.bad_op};
			board.check_response(got);
			progress = 1'b1;
		end
		idle_cycles <= progress ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("mips_load_store_align_merge_top_tb failed");
			$finish;
		end
	end

	function automatic data_t pick_data();
		data_t v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = '0;
			1: v = '1;
			2: v = {v[63:32], 1'b1, v[30:16], 1'b1, v[14:8], 1'b1, v[6:0]};
			3: v = {v[63:32], 1'b0, v[30:16], 1'b0, v[14:8], 1'b0, v[6:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_access(op_code_t op, addr_t addr, idx_t idx, data_t rv, data_t md,
		logic ok);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op;
		req_ch.eff_addr     <= addr;
		req_ch.target_index <= idx;
		req_ch.reg_value    <= rv;
		req_ch.mem_data     <= md;
		req_ch.mem_ok       <= ok;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic run_phase(int items, int s_pct, int r_pct);
		op_code_t op;
		addr_t    addr;
		int       pick;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (items) begin
			pick = $urandom_range(99);
			if (pick < 6)
				op = op_code_t'($urandom_range(31, OP_SDR + 1));
			else if (pick < 16)
				op = OP_LL;
			else if (pick < 26)
				op = OP_SC;
			else
				op = op_code_t'($urandom_range(OP_SDR, OP_LW));
			case ($urandom_range(9))
				0: addr = '0;
				1: addr = '1;
				default: addr = $urandom;
			endcase
			send_access(op, addr, idx_t'($urandom), pick_data(), pick_data(),
				$urandom_range(99) < 85);
		end
		drain_responses();
	endtask

	initial begin
		addr_t addr_set[4];
		data_t reg_set[3];
		board = new();
		addr_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0006};
		reg_set  = '{64'hFEDC_BA98_7654_3210, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
		send_idle_pct = 28;
		recv_idle_pct = 66;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.op           <= OP_LW;
		req_ch.eff_addr     <= '0;
		req_ch.target_index <= '0;
		req_ch.reg_value    <= '0;
		req_ch.mem_data     <= '0;
		req_ch.mem_ok       <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = OP_LW; k <= OP_SDR; k++) begin
			send_access(op_code_t'(k), addr_set[k % 4], (k % 2) ? '1 : '0, reg_set[k % 3],
				(k % 2) ? 64'h0123_4567_89AB_CDEF : 64'hFFFF_FFFF_FFFF_FFFF, k != OP_LWU);
		end
		send_access(OP_SC, 32'h0000_1000, 5'd7, 64'hAAAA_5555_AAAA_5555, '0, 1'b1);
		send_access(op_code_t'('1), '1, '1, '1, '1, 1'b1);
		drain_responses();

		run_phase(170, 28, 66);
		run_phase(170, 66, 28);
		run_phase(160, 0, 0);

		repeat (6) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("mips_load_store_align_merge_top_tb passed");
		else
			$display("mips_load_store_align_merge_top_tb failed");
		$finish;
	end

endmodule

// File: mips_load_store_align_merge_top.f
hw/rtl/mlsam_pkg.sv
hw/rtl/mlsam_req_if.sv
hw/rtl/mlsam_rsp_if.sv
hw/rtl/mips_load_store_align_merge_top.sv
sim/mips_load_store_align_merge_top_tb.sv
